FILE: hdl/srdiv_pkg.sv
// ----------------------------------------------------------------------------
// srdiv_pkg
// Shared types for the signed restoring divider pipeline.
// ----------------------------------------------------------------------------
package srdiv_pkg;

  // Sign and exception flags that travel down the pipeline with each word
  typedef struct packed {
    logic num_neg;   // dividend is negative
    logic den_neg;   // divisor is negative
    logic div_zero;  // divisor is zero
  } srdiv_flags_t;

endpackage : srdiv_pkg

FILE: hdl/signed_restoring_divider.sv
// ----------------------------------------------------------------------------
// signed_restoring_divider
// Fully pipelined signed restoring divider: one quotient bit per stage.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Handshake              | Word
//  --------+-----------+------------------------+----------------------------------
//  in      | sink      | in_valid_i/in_ready_o   | numerator_i, denominator_i
//  out     | source    | out_valid_o/out_ready_i | quotient_o, remainder_out_o,
//          |           |                         | divide_by_zero_o
//
//  One stage takes the operand magnitudes, WIDTH stages each resolve one
//  quotient bit with a (WIDTH+2)-bit compare and subtract, and one stage
//  fixes the result signs.
//  While the output is not stalled, a new word enters every cycle; throughput is one word per clock.
//  Reset clears only the valid bits; the data registers are left as they are.
//  A stall at the output freezes the whole pipeline at once, so no word is
//  dropped or repeated, and in_ready_o follows the output register's state and out_ready_i.
//
module signed_restoring_divider
  import srdiv_pkg::*;
#(
  parameter int WIDTH = 32
) (
  input  logic               clk_i,
  input  logic               rst_ni,

  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  logic signed [31:0] numerator_i,
  input  logic signed [31:0] denominator_i,

  output logic               out_valid_o,
  input  logic               out_ready_i,
  output logic signed [31:0] quotient_o,
  output logic signed [31:0] remainder_out_o,
  output logic               divide_by_zero_o
);

  localparam int Steps = WIDTH;

  // Pipeline advance: the whole chain moves when the output register is free
  // or being drained this cycle.
  logic advance;

  // Stage 0 holds magnitudes; stage k holds the state after k restoring steps.
  logic [Steps:0]        vld_q;
  logic [WIDTH-1:0]      quo_q   [Steps+1];
  logic [WIDTH-1:0]      rem_q   [Steps+1];
  logic [WIDTH-1:0]      den_q   [Steps+1];
  srdiv_flags_t          flags_q [Steps+1];

  // Output register
  logic                      out_valid_q;
  logic signed [WIDTH-1:0]   out_quo_q;
  logic signed [WIDTH-1:0]   out_rem_q;
  srdiv_flags_t              out_flags_q;

  assign advance    = !out_valid_q || out_ready_i;
  assign in_ready_o = advance;

  // --------------------------------------------------------------------------
  // Input stage: bring operands to WIDTH bits, take magnitudes.
  // A size cast of a signed port sign-extends or truncates as WIDTH demands.
  // --------------------------------------------------------------------------
  logic signed [WIDTH-1:0] num_w;
  logic signed [WIDTH-1:0] den_w;
  logic [WIDTH-1:0]        num_mag;
  logic [WIDTH-1:0]        den_mag;
  srdiv_flags_t            in_flags;

  always_comb begin
    num_w             = WIDTH'(numerator_i);
    den_w             = WIDTH'(denominator_i);
    in_flags.num_neg  = num_w[WIDTH-1];
    in_flags.den_neg  = den_w[WIDTH-1];
    in_flags.div_zero = (den_w == '0);
    // Unsigned magnitudes: the most-negative value maps to 2^(WIDTH-1)
    num_mag = in_flags.num_neg ? WIDTH'(-num_w) : WIDTH'(num_w);
    den_mag = in_flags.den_neg ? WIDTH'(-den_w) : WIDTH'(den_w);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q[0] <= 1'b0;
    end else if (advance) begin
      vld_q[0] <= in_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      quo_q[0]   <= num_mag;
      rem_q[0]   <= '0;
      den_q[0]   <= den_mag;
      flags_q[0] <= in_flags;
    end
  end

  // --------------------------------------------------------------------------
  // Restoring stages: shift the next dividend bit into the partial remainder,
  // subtract the divisor, keep the difference only when it does not borrow.
  // The quotient bit shifts in where the dividend bit left.
  // A zero divisor never borrows, so the quotient fills with ones and the
  // remainder ends equal to the dividend magnitude.
  // --------------------------------------------------------------------------
  for (genvar k = 1; k <= Steps; k++) begin : g_step
    logic [WIDTH+1:0] rem_shift;
    logic [WIDTH+1:0] diff;
    logic             fits;
    logic [WIDTH-1:0] rem_d;
    logic [WIDTH-1:0] quo_d;

    always_comb begin
      rem_shift = {1'b0, rem_q[k-1], quo_q[k-1][WIDTH-1]};
      diff      = rem_shift - {2'b00, den_q[k-1]};
      fits      = !diff[WIDTH+1];
      rem_d     = fits ? diff[WIDTH-1:0] : rem_shift[WIDTH-1:0];
      quo_d     = {quo_q[k-1][WIDTH-2:0], fits};
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        vld_q[k] <= 1'b0;
      end else if (advance) begin
        vld_q[k] <= vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (advance) begin
        quo_q[k]   <= quo_d;
        rem_q[k]   <= rem_d;
        den_q[k]   <= den_q[k-1];
        flags_q[k] <= flags_q[k-1];
      end
    end
  end

  // --------------------------------------------------------------------------
  // Sign fix-up: negate the quotient when the signs differ, give the
  // remainder the dividend's sign. Most-negative over minus one wraps here.
  // --------------------------------------------------------------------------
  logic signed [WIDTH-1:0] quo_fix;
  logic signed [WIDTH-1:0] rem_fix;

  always_comb begin
    quo_fix = (flags_q[Steps].num_neg != flags_q[Steps].den_neg)
              ? WIDTH'(-quo_q[Steps]) : WIDTH'(quo_q[Steps]);
    rem_fix = flags_q[Steps].num_neg ? WIDTH'(-rem_q[Steps]) : WIDTH'(rem_q[Steps]);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (advance) begin
      out_valid_q <= vld_q[Steps];
    end
  end

  always_ff @(posedge clk_i) begin
    if (advance) begin
      out_quo_q   <= quo_fix;
      out_rem_q   <= rem_fix;
      out_flags_q <= flags_q[Steps];
    end
  end

  // Results sign-extend or truncate to the 32-bit ports
  assign out_valid_o      = out_valid_q;
  assign quotient_o       = 32'(out_quo_q);
  assign remainder_out_o  = 32'(out_rem_q);
  assign divide_by_zero_o = out_flags_q.div_zero;

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------

  // A held output freezes every stage's valid bit
  a_stall_freezes: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !advance |=> $stable(vld_q) && $stable(out_valid_q))
    else $error("pipeline valid bits moved during an output stall");

  // The zero-divisor flag agrees with the registered divisor magnitude
  a_zero_flag: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[0] |-> (flags_q[0].div_zero == (den_q[0] == '0)))
    else $error("zero-divisor flag disagrees with divisor");

  // After the last step the remainder magnitude is below a nonzero divisor
  a_rem_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_q[Steps] && !flags_q[Steps].div_zero |-> rem_q[Steps] < den_q[Steps])
    else $error("final remainder not below divisor");

  // The remainder never carries a sign opposite to the dividend
  a_rem_sign: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q && (out_rem_q != '0) |-> out_rem_q[WIDTH-1] == out_flags_q.num_neg)
    else $error("remainder sign differs from dividend sign");

endmodule : signed_restoring_divider

FILE: dv/tb_signed_restoring_divider.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_signed_restoring_divider
// Self-checking bench for the pipelined signed divider.
// Operand words come from a queue that holds a directed set first and a
// random mix after it. Each accepted word is divided by a bit-serial model
// inside the bench. Every result word leaving the block is checked against
// the oldest prediction. Both handshakes stall at random, and once the
// output holds off long enough for the pipeline to back up into its input.
// ----------------------------------------------------------------------------
module tb_signed_restoring_divider;

  localparam int DIV_W       = 32;
  localparam int IDLE_LIMIT  = 2000;  // cycles with no handshake before giving up
  localparam int HOLD_CYCLES = 200;   // long output hold-off, well past pipeline depth
  localparam int HOLD_AFTER  = 400;   // input words accepted before the hold-off
  localparam int RANDOM_WORDS = 1200;

  localparam logic [31:0] MOST_NEG = 32'h8000_0000;
  localparam logic [31:0] MOST_POS = 32'h7FFF_FFFF;
  localparam logic [31:0] MINUS_1  = 32'hFFFF_FFFF;

  typedef struct packed {
    logic [31:0] num;
    logic [31:0] den;
  } operand_pair_t;

  typedef struct packed {
    logic [31:0] quo;
    logic [31:0] rem;
    logic        dbz;
  } div_result_t;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;

  logic               in_valid_i = 1'b0;
  logic               in_ready_o;
  logic signed [31:0] numerator_i = '0;
  logic signed [31:0] denominator_i = '0;

  logic               out_valid_o;
  logic               out_ready_i = 1'b0;
  logic signed [31:0] quotient_o;
  logic signed [31:0] remainder_out_o;
  logic               divide_by_zero_o;

  operand_pair_t pending_words[$];
  div_result_t   expected_results[$];

  int  error_count = 0;
  int  words_in = 0;
  int  idle_cycles = 0;
  bit  in_taken = 1'b0;    // last rising edge moved an input word
  bit  hold_off = 1'b0;    // receiver forced off
  bit  send_calm = 1'b0;   // sender runs back to back while set
  bit  recv_calm = 1'b0;   // receiver runs back to back while set
  int  send_gap = 0;
  int  recv_gap = 0;

  signed_restoring_divider #(
    .WIDTH(DIV_W)
  ) u_dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .in_valid_i      (in_valid_i),
    .in_ready_o      (in_ready_o),
    .numerator_i     (numerator_i),
    .denominator_i   (denominator_i),
    .out_valid_o     (out_valid_o),
    .out_ready_i     (out_ready_i),
    .quotient_o      (quotient_o),
    .remainder_out_o (remainder_out_o),
    .divide_by_zero_o(divide_by_zero_o)
  );

  always #6 clk_i = ~clk_i;

  // Divide the magnitudes one quotient bit at a time, restoring on a failed
  // subtract, then put the signs back: quotient negative when the operand
  // signs differ, remainder follows the dividend. A zero divisor never fails
  // the compare, so the quotient comes out all ones and the remainder holds
  // the dividend magnitude.
  function automatic div_result_t divide_signed(logic [31:0] num, logic [31:0] den);
    logic        num_neg;
    logic        den_neg;
    logic [31:0] num_mag;
    logic [31:0] den_mag;
    logic [31:0] quo;
    logic [32:0] part;
    div_result_t res;
    num_neg = num[31];
    den_neg = den[31];
    num_mag = num_neg ? -num : num;
    den_mag = den_neg ? -den : den;
    quo  = num_mag;
    part = '0;
    for (int i = 0; i < DIV_W; i++) begin
      part = {part[31:0], quo[31]};
      quo  = quo << 1;
      if (part >= {1'b0, den_mag}) begin
        part   = part - {1'b0, den_mag};
        quo[0] = 1'b1;
      end
    end
    res.quo = (num_neg != den_neg) ? -quo : quo;
    res.rem = num_neg ? -part[31:0] : part[31:0];
    res.dbz = (den == '0);
    return res;
  endfunction

  // Mostly short gaps, now and then a long one; none at all in calm stretches.
  function automatic int pick_gap(bit calm);
    int roll;
    roll = $urandom_range(0, 99);
    if (calm || roll < 60) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Random value of random bit length with a random sign, so quotients and
  // remainders of every size show up.
  function automatic logic [31:0] ranged_word();
    logic [31:0] mag;
    mag = $urandom() >> $urandom_range(0, 31);
    return $urandom_range(0, 1) ? -mag : mag;
  endfunction

  function automatic operand_pair_t random_pair();
    operand_pair_t p;
    int kind;
    kind = $urandom_range(0, 99);
    p.num = $urandom();
    p.den = $urandom();
    if (kind < 30) begin
      // full-range words: every operand bit toggles here
    end else if (kind < 60) begin
      p.num = ranged_word();
      p.den = ranged_word();
    end else if (kind < 75) begin
      p.num = $urandom_range(0, 1) ? -($urandom_range(0, 99)) : $urandom_range(0, 99);
      p.den = $urandom_range(0, 1) ? -($urandom_range(1, 12)) : $urandom_range(1, 12);
    end else if (kind < 82) begin
      p.den = '0;
    end else if (kind < 89) begin
      p.den = $urandom_range(0, 1) ? MINUS_1 : 32'd1;
    end else if (kind < 95) begin
      p.num = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
      p.den = ranged_word();
    end else begin
      p.den = $urandom_range(0, 1) ? MOST_NEG : MOST_POS;
    end
    return p;
  endfunction

  // Drive the input channel at the falling edge. Hold a word until the rising
  // edge has taken it, then either idle for the chosen gap or offer the next.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) begin
      send_calm <= !send_calm;
    end
    if (!rst_ni) begin
      in_valid_i <= 1'b0;
    end else if (in_valid_i && !in_taken) begin
      // hold the offered word
    end else if (send_gap > 0) begin
      in_valid_i <= 1'b0;
      send_gap   <= send_gap - 1;
    end else if (pending_words.size() > 0) begin
      operand_pair_t p;
      p = pending_words.pop_front();
      in_valid_i    <= 1'b1;
      numerator_i   <= p.num;
      denominator_i <= p.den;
      send_gap      <= pick_gap(send_calm);
    end else begin
      in_valid_i <= 1'b0;
    end
  end

  // Drive ready at the falling edge: forced low during the long hold-off,
  // otherwise high for one cycle followed by a random gap.
  always @(negedge clk_i) begin
    if ($urandom_range(0, 199) == 0) begin
      recv_calm <= !recv_calm;
    end
    if (hold_off) begin
      out_ready_i <= 1'b0;
    end else if (recv_gap > 0) begin
      out_ready_i <= 1'b0;
      recv_gap    <= recv_gap - 1;
    end else begin
      out_ready_i <= 1'b1;
      recv_gap    <= pick_gap(recv_calm);
    end
  end

  // Sample both channels at the rising edge. Check the output word first and
  // predict from the input word after, so the order within one edge is fixed.
  // Also run the watchdog on cycles where neither channel moves a word.
  always @(posedge clk_i) begin
    bit in_fire;
    bit out_fire;
    in_fire  = rst_ni && in_valid_i && in_ready_o;
    out_fire = rst_ni && out_valid_o && out_ready_i;
    in_taken <= in_fire;

    if (out_fire) begin
      if (expected_results.size() == 0) begin
        $error("result word with nothing expected: quotient %0d remainder_out %0d",
               quotient_o, remainder_out_o);
        error_count++;
      end else begin
        div_result_t want;
        want = expected_results.pop_front();
        if (quotient_o !== want.quo) begin
          $error("quotient: expected %0d, got %0d", $signed(want.quo), quotient_o);
          error_count++;
        end
        if (remainder_out_o !== want.rem) begin
          $error("remainder_out: expected %0d, got %0d", $signed(want.rem),
                 remainder_out_o);
          error_count++;
        end
        if (divide_by_zero_o !== want.dbz) begin
          $error("divide_by_zero: expected %0b, got %0b", want.dbz, divide_by_zero_o);
          error_count++;
        end
      end
    end

    if (in_fire) begin
      expected_results.push_back(divide_signed(numerator_i, denominator_i));
      words_in++;
    end

    if (in_fire || out_fire || !rst_ni) begin
      idle_cycles = 0;
    end else begin
      idle_cycles++;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("tb_signed_restoring_divider: done, errors");
        $finish;
      end
    end
  end

  // Long output hold-off: starve the receiver while the sender keeps going,
  // so the pipeline fills and in_ready_o has to drop.
  initial begin
    while (words_in < HOLD_AFTER) @(posedge clk_i);
    hold_off = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk_i);
    hold_off = 1'b0;
  end

  // Fill the stimulus queue, release reset, wait for the last result to drain.
  initial begin
    operand_pair_t directed[$];
    directed = '{
      '{32'd0, 32'd1},        '{32'd1, 32'd1},        '{MINUS_1, 32'd1},
      '{MOST_NEG, 32'd1},     '{MOST_NEG, MINUS_1},   '{MOST_POS, MINUS_1},
      '{MOST_NEG, MOST_NEG},  '{MOST_POS, MOST_POS},  '{MOST_NEG, MOST_POS},
      '{MOST_POS, MOST_NEG},  '{32'd7, 32'd2},        '{-32'sd7, 32'd2},
      '{32'd7, -32'sd2},      '{-32'sd7, -32'sd2},    '{32'd5, 32'd0},
      '{-32'sd5, 32'd0},      '{32'd0, 32'd0},        '{MOST_NEG, 32'd0},
      '{MOST_POS, 32'd0},     '{32'd3, 32'd7},        '{-32'sd3, 32'd7},
      '{32'd1, MOST_NEG},     '{32'd12345, MINUS_1},  '{32'hAAAA_AAAA, 32'h5555_5555},
      '{32'h5555_5555, 32'hAAAA_AAAA}
    };
    foreach (directed[i]) pending_words.push_back(directed[i]);
    for (int i = 0; i < RANDOM_WORDS; i++) pending_words.push_back(random_pair());

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // Everything offered and taken, then every prediction matched, then a
    // pipeline's worth of quiet to catch stray words.
    while (pending_words.size() > 0 || in_valid_i) @(posedge clk_i);
    while (expected_results.size() > 0) @(posedge clk_i);
    repeat (DIV_W + 12) @(posedge clk_i);

    if (error_count == 0) begin
      $display("tb_signed_restoring_divider: done, clean");
    end else begin
      $display("tb_signed_restoring_divider: done, errors");
    end
    $finish;
  end

endmodule
